// File: design/tcpv_pkg.sv
package tcpv_pkg;

	localparam int unsigned COORD_W       = 32;
	localparam int unsigned PROD_W        = 2 * COORD_W;
	localparam int unsigned MAG_W         = PROD_W - 1;
	localparam int unsigned Q_W           = COORD_W;
	localparam int unsigned BITS_PER_STEP = 2;
	localparam int unsigned DIV_STEPS     = Q_W / BITS_PER_STEP;
	// abs stage, quotient steps, fix-up stage
	localparam int unsigned DIV_LAT       = DIV_STEPS + 2;
	// multiply stage, divider, screen stage
	localparam int unsigned N_STAGES      = DIV_LAT + 2;
	localparam int unsigned N_VERT        = 3;
	localparam int unsigned N_COORD       = 2 * N_VERT;
	localparam int unsigned CFG_IDX_W     = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR      = 3'd0,
		REG_FAR       = 3'd1,
		REG_VIEW_DIST = 3'd2,
		REG_CENTER_X  = 3'd3,
		REG_CENTER_Y  = 3'd4
	} cfg_reg_t;

	localparam coord_t NEAR_RESET      = 32'sh0001_0000;
	localparam coord_t FAR_RESET       = 32'sh0400_0000;
	localparam coord_t VIEW_DIST_RESET = 32'sh0001_0000;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		coord_t near_plane;
		coord_t far_plane;
		coord_t view_distance;
		coord_t center_x;
		coord_t center_y;
	} cfg_t;

	typedef struct packed {
		logic kept;
		logic last;
	} side_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic pzero;
	} div_flag_t;

	function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
		if (v[COORD_W] != v[COORD_W-1]) begin
			return v[COORD_W] ? COORD_MIN : COORD_MAX;
		end
		return v[COORD_W-1:0];
	endfunction

endpackage

// File: design/tcpv_in_if.sv
interface tcpv_in_if import tcpv_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t a_x;
	coord_t a_y;
	coord_t a_z;
	coord_t b_x;
	coord_t b_y;
	coord_t b_z;
	coord_t c_x;
	coord_t c_y;
	coord_t c_z;
	logic   last_face;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_face,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_face,
		output ready
	);
endinterface

// File: design/tcpv_out_if.sv
interface tcpv_out_if import tcpv_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   face_kept;
	coord_t sa_x;
	coord_t sa_y;
	coord_t sb_x;
	coord_t sb_y;
	coord_t sc_x;
	coord_t sc_y;
	logic   last_out;

	modport source (
		output valid, face_kept, sa_x, sa_y, sb_x, sb_y, sc_x, sc_y, last_out,
		input  ready
	);
	modport sink (
		input  valid, face_kept, sa_x, sa_y, sb_x, sb_y, sc_x, sc_y, last_out,
		output ready
	);
endinterface

// File: design/tcpv_mul.sv
module tcpv_mul import tcpv_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  coord_t vx [N_VERT],
	input  coord_t vy [N_VERT],
	input  coord_t vz [N_VERT],
	input  logic   last,
	input  coord_t near_plane,
	input  coord_t far_plane,
	input  coord_t view_distance,
	output prod_t  prod_s1 [N_COORD],
	output coord_t z_s1 [N_VERT],
	output side_t  side_s1
);

	coord_t min01;
	coord_t minz;
	logic   kept;

	always_comb begin
		min01 = (vz[1] < vz[0]) ? vz[1] : vz[0];
		minz  = (vz[2] < min01) ? vz[2] : min01;
		kept  = !((minz < near_plane) || (minz > far_plane));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_VERT; i++) begin
				prod_s1[2*i]   <= prod_t'(vx[i]) * prod_t'(view_distance);
				prod_s1[2*i+1] <= prod_t'(vy[i]) * prod_t'(view_distance);
				z_s1[i]        <= vz[i];
			end
			side_s1.kept <= kept;
			side_s1.last <= last;
		end
	end

endmodule

// File: design/tcpv_div.sv
module tcpv_div import tcpv_pkg::*; (
	input  logic               clk,
	input  logic [DIV_LAT-1:0] en,
	input  prod_t              prod,
	input  coord_t             z,
	output coord_t             quo
);

	logic [MAG_W-1:0] pm;
	logic [Q_W-1:0]   zm;
	prod_t            prod_neg;
	coord_t           z_neg;
	div_flag_t        flag_in;

	logic [MAG_W-1:0] rem_s  [DIV_STEPS];
	logic [Q_W-1:0]   den_s  [DIV_STEPS];
	logic [Q_W-1:0]   quo_s  [DIV_STEPS+1];
	div_flag_t        flag_s [DIV_STEPS+1];
	coord_t           quo_s19;
	coord_t           fix;

	// magnitudes; quotient needs only Q_W bits once overflow is flagged
	always_comb begin
		prod_neg      = -prod;
		z_neg         = -z;
		pm            = prod[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];
		zm            = z[COORD_W-1] ? z_neg : z;
		flag_in.neg   = prod[PROD_W-1] ^ z[COORD_W-1];
		flag_in.pzero = (prod == '0);
		flag_in.ovf   = ({1'b0, pm} >= {zm, {Q_W{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= pm;
			den_s[0]  <= zm;
			quo_s[0]  <= '0;
			flag_s[0] <= flag_in;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [MAG_W-1:0] r;
		logic [MAG_W-1:0] trial;
		logic [Q_W-1:0]   qn;

		always_comb begin
			r  = rem_s[k-1];
			qn = quo_s[k-1];
			for (int b = 0; b < BITS_PER_STEP; b++) begin
				trial = MAG_W'(den_s[k-1]) << (Q_W - (k-1)*BITS_PER_STEP - 1 - b);
				if (r >= trial) begin
					r  = r - trial;
					qn = {qn[Q_W-2:0], 1'b1};
				end else begin
					qn = {qn[Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k]  <= qn;
				flag_s[k] <= flag_s[k-1];
			end
		end

		if (k < DIV_STEPS) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= r;
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	// apply sign, saturate on overflow or zero depth
	always_comb begin
		if (flag_s[DIV_STEPS].pzero) begin
			fix = '0;
		end else if (flag_s[DIV_STEPS].ovf || quo_s[DIV_STEPS][Q_W-1]) begin
			fix = flag_s[DIV_STEPS].neg ? COORD_MIN : COORD_MAX;
		end else if (flag_s[DIV_STEPS].neg) begin
			fix = -coord_t'(quo_s[DIV_STEPS]);
		end else begin
			fix = coord_t'(quo_s[DIV_STEPS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[DIV_LAT-1]) begin
			quo_s19 <= fix;
		end
	end

	assign quo = quo_s19;

endmodule

// File: design/tcpv_view.sv
module tcpv_view import tcpv_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  side_t  side,
	input  coord_t center_x,
	input  coord_t center_y,
	input  coord_t px [N_VERT],
	input  coord_t py [N_VERT],
	output logic   face_kept,
	output logic   last_out,
	output coord_t sx [N_VERT],
	output coord_t sy [N_VERT]
);

	coord_t sx_d [N_VERT];
	coord_t sy_d [N_VERT];
	coord_t sx_s20 [N_VERT];
	coord_t sy_s20 [N_VERT];
	logic   kept_s20;
	logic   last_s20;

	always_comb begin
		for (int i = 0; i < N_VERT; i++) begin
			sx_d[i] = sat_coord({center_x[COORD_W-1], center_x} + {px[i][COORD_W-1], px[i]});
			sy_d[i] = sat_coord({center_y[COORD_W-1], center_y} - {py[i][COORD_W-1], py[i]});
		end
	end

	// zero the coordinates of a cut face
	always_ff @(posedge clk) begin
		if (en) begin
			kept_s20 <= side.kept;
			last_s20 <= side.last;
			for (int i = 0; i < N_VERT; i++) begin
				sx_s20[i] <= side.kept ? sx_d[i] : '0;
				sy_s20[i] <= side.kept ? sy_d[i] : '0;
			end
		end
	end

	assign face_kept = kept_s20;
	assign last_out  = last_s20;
	assign sx        = sx_s20;
	assign sy        = sy_s20;

endmodule

// File: design/triangle_clip_project_viewport_top.sv
// channel   | dir | beat contents                                  | handshake
// ----------+-----+------------------------------------------------+-------------
// face      | in  | a/b/c vertex x,y,z (Q16.16), last_face         | valid/ready
// screen    | out | face_kept, sa/sb/sc screen x,y (Q16.16), last  | valid/ready
// cfg       | in  | cfg_we, cfg_index, cfg_wdata                   | write enable
//
// One face beat per cycle unless screen stalls. Path: multiply, quotient, screen.
// The depth is set by the quotient unit: two quotient bits per stage over 32 bits.
// arst_n clears the valid bits and loads the configuration reset values.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles close up under a stalled screen channel and nothing is lost or repeated.
module triangle_clip_project_viewport_top import tcpv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata,
	tcpv_in_if.sink              face,
	tcpv_out_if.source           screen
);

	cfg_t                cfg_q;
	logic [N_STAGES-1:0] vld_s;
	logic [N_STAGES-1:0] en;

	coord_t vx [N_VERT];
	coord_t vy [N_VERT];
	coord_t vz [N_VERT];

	prod_t  prod_s1 [N_COORD];
	coord_t z_s1 [N_VERT];
	side_t  side_s1;
	side_t  side_s [1:DIV_LAT];
	coord_t quo [N_COORD];
	coord_t px [N_VERT];
	coord_t py [N_VERT];
	coord_t sx [N_VERT];
	coord_t sy [N_VERT];

	// configuration registers; out-of-range indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_plane    <= NEAR_RESET;
			cfg_q.far_plane     <= FAR_RESET;
			cfg_q.view_distance <= VIEW_DIST_RESET;
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NEAR:      cfg_q.near_plane    <= cfg_wdata;
				REG_FAR:       cfg_q.far_plane     <= cfg_wdata;
				REG_VIEW_DIST: cfg_q.view_distance <= cfg_wdata;
				REG_CENTER_X:  cfg_q.center_x      <= cfg_wdata;
				REG_CENTER_Y:  cfg_q.center_y      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or its successor advances
	always_comb begin
		en[N_STAGES-1] = !vld_s[N_STAGES-1] || screen.ready;
		for (int i = N_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= face.valid;
			end
			for (int i = 1; i < N_STAGES; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign face.ready = en[0];

	assign vx[0] = face.a_x;
	assign vy[0] = face.a_y;
	assign vz[0] = face.a_z;
	assign vx[1] = face.b_x;
	assign vy[1] = face.b_y;
	assign vz[1] = face.b_z;
	assign vx[2] = face.c_x;
	assign vy[2] = face.c_y;
	assign vz[2] = face.c_z;

	// stage 1: depth test and coordinate times view distance
	tcpv_mul u_mul (
		.clk           (clk),
		.en            (en[0]),
		.vx            (vx),
		.vy            (vy),
		.vz            (vz),
		.last          (face.last_face),
		.near_plane    (cfg_q.near_plane),
		.far_plane     (cfg_q.far_plane),
		.view_distance (cfg_q.view_distance),
		.prod_s1       (prod_s1),
		.z_s1          (z_s1),
		.side_s1       (side_s1)
	);

	// carry the keep flag and last marker alongside the quotient units
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s[1] <= side_s1;
		end
		for (int i = 2; i <= DIV_LAT; i++) begin
			if (en[i]) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// one quotient unit per projected coordinate, x and y of each vertex
	for (genvar j = 0; j < N_COORD; j++) begin : g_div
		tcpv_div u_div (
			.clk  (clk),
			.en   (en[DIV_LAT:1]),
			.prod (prod_s1[j]),
			.z    (z_s1[j/2]),
			.quo  (quo[j])
		);
	end

	for (genvar i = 0; i < N_VERT; i++) begin : g_vert
		assign px[i] = quo[2*i];
		assign py[i] = quo[2*i+1];
	end

	// last stage: screen offset, saturate, zero a cut face
	tcpv_view u_view (
		.clk       (clk),
		.en        (en[N_STAGES-1]),
		.side      (side_s[DIV_LAT]),
		.center_x  (cfg_q.center_x),
		.center_y  (cfg_q.center_y),
		.px        (px),
		.py        (py),
		.face_kept (screen.face_kept),
		.last_out  (screen.last_out),
		.sx        (sx),
		.sy        (sy)
	);

	assign screen.valid = vld_s[N_STAGES-1];
	assign screen.sa_x  = sx[0];
	assign screen.sa_y  = sy[0];
	assign screen.sb_x  = sx[1];
	assign screen.sb_y  = sy[1];
	assign screen.sc_x  = sx[2];
	assign screen.sc_y  = sy[2];

endmodule
